// ===== rtl/wrm_pkg.sv =====
// ----------------------------------------------------------------------------
// wrm_pkg
// Types and constants shared by the windowed rate meter modules.
// ----------------------------------------------------------------------------
package wrm_pkg;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [25:0] SCALE_K = 26'd65536000;

  typedef struct packed {
    logic        command;
    logic [2:0]  thread;
    logic [63:0] sample_count;
    logic [63:0] sample_time;
    logic [63:0] query_time;
    logic [31:0] window_ms;
  } wrm_in_t;

  typedef struct packed {
    logic [63:0] rate_value;
    logic        rate_valid;
  } wrm_out_t;

endpackage

// ===== rtl/windowed_rate_meter_core.sv =====
// ----------------------------------------------------------------------------
// windowed_rate_meter_core
// Per-thread rings of (count, timestamp) samples with windowed rate query.
// ----------------------------------------------------------------------------
// Usage: words enter on in/in_valid/in_stall; query results leave on
// out/out_valid/out_stall. An add word writes one sample and produces no
// result. A query walks back over the ring one sample per cycle through
// the sample RAMs (one read port each), up to RING_DEPTH-1 samples, then
// runs a 64-step divider. One word is in work at a time.
// After reset a clearing pass zeroes every ring entry, one per cycle;
// in_stall stays high meanwhile.
// A stalled result holds in the output register; the block takes no new
// word until it is taken.
// ----------------------------------------------------------------------------
module windowed_rate_meter_core
  import wrm_pkg::*;
#(
  parameter int THREADS    = 8,
  parameter int RING_DEPTH = 4096
) (
  input  logic     clk,
  input  logic     rst,
  input  wrm_in_t  in,
  input  logic     in_valid,
  output logic     in_stall,
  output wrm_out_t out,
  output logic     out_valid,
  input  logic     out_stall
);

  localparam int TW   = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int RW   = $clog2(RING_DEPTH);
  localparam int DEP  = THREADS * RING_DEPTH;
  localparam int AW   = $clog2(DEP);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HEAD  = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  wrm_in_t cmd;
  logic [AW:0] clr;

  logic          hwe;
  logic [TW-1:0] hwaddr, hraddr;
  logic [RW-1:0] hwdata, hrdata;

  logic          swe;
  logic [AW-1:0] swaddr, sraddr;
  logic [63:0]   cwdata, twdata, crdata, trdata;

  logic [RW-1:0] head, idx;
  logic [RW:0]   steps;
  logic          pend;
  logic          have_new, have_old, full;
  logic [63:0]   new_t, new_c, old_t, old_c;
  logic [63:0]   dc, dt;
  logic [63:0]   m_lo, m_hi;
  logic          div_start, div_done;
  logic [63:0]   quot;
  logic          thr_ok;

  assign thr_ok = 32'(in.thread) < THREADS;

  function automatic logic [AW-1:0] addr_of(input logic [2:0] t, input logic [RW-1:0] i);
    return AW'(32'(t) * RING_DEPTH + 32'(i));
  endfunction

  function automatic logic [RW-1:0] dec(input logic [RW-1:0] i);
    return (i == '0) ? RW'(RING_DEPTH - 1) : RW'(i - 1'b1);
  endfunction

  wrm_ram #(.WIDTH(RW), .DEPTH(1 << TW)) u_head (
    .clk, .we(hwe), .waddr(hwaddr), .wdata(hwdata), .raddr(hraddr), .rdata(hrdata));
  wrm_ram #(.WIDTH(64), .DEPTH(DEP)) u_count (
    .clk, .we(swe), .waddr(swaddr), .wdata(cwdata), .raddr(sraddr), .rdata(crdata));
  wrm_ram #(.WIDTH(64), .DEPTH(DEP)) u_time (
    .clk, .we(swe), .waddr(swaddr), .wdata(twdata), .raddr(sraddr), .rdata(trdata));

  wrm_div u_div (
    .clk, .rst, .start(div_start), .hi(m_hi), .lo(m_lo), .divisor(dt),
    .done(div_done), .quotient(quot));

  assign in_stall = (state != S_IDLE);
  assign hraddr   = in.thread[TW-1:0];

  // Head RAM is also cleared during the sweep (while clr is below 1 << TW).
  always_comb begin
    hwe    = 1'b0;
    hwaddr = cmd.thread[TW-1:0];
    hwdata = (head == RW'(RING_DEPTH - 1)) ? '0 : RW'(head + 1'b1);
    swe    = 1'b0;
    swaddr = addr_of(cmd.thread, head);
    cwdata = cmd.sample_count;
    twdata = cmd.sample_time;
    sraddr = addr_of(cmd.thread, pend ? dec(idx) : idx);
    if (state == S_CLEAR) begin
      swe    = 1'b1;
      swaddr = clr[AW-1:0];
      cwdata = '0;
      twdata = '0;
      hwe    = clr < (AW+1)'(1 << TW);
      hwaddr = clr[TW-1:0];
      hwdata = '0;
    end else if (state == S_HEAD && cmd.command == CMD_ADD) begin
      swe = 1'b1;
      hwe = 1'b1;
    end
  end

  assign head = hrdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(DEP - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd <= in;
            if (!thr_ok) begin
              if (in.command == CMD_QUERY) begin
                out       <= '0;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          if (cmd.command == CMD_ADD) begin
            state <= S_IDLE;
          end else begin
            idx      <= dec(head);
            steps    <= (RW+1)'(1);
            pend     <= 1'b0;
            have_new <= 1'b0;
            have_old <= 1'b0;
            full     <= 1'b0;
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          // pend: read data of previous address is valid now
          if (pend) begin
            if (trdata == '0) begin
              state <= S_EVAL;
            end else begin
              if (!have_new) begin
                have_new <= 1'b1;
                new_t    <= trdata;
                new_c    <= crdata;
              end
              if (64'(cmd.query_time - trdata) > {32'd0, cmd.window_ms}) begin
                full  <= 1'b1;
                state <= S_EVAL;
              end else begin
                have_old <= 1'b1;
                old_t    <= trdata;
                old_c    <= crdata;
                if (steps == (RW+1)'(RING_DEPTH - 1)) state <= S_EVAL;
              end
            end
          end
          if (state == S_WALK) begin
            pend  <= 1'b1;
            if (pend) begin
              idx   <= dec(idx);
              steps <= steps + 1'b1;
            end
          end
        end
        S_EVAL: begin
          if (!full || !have_old || !have_new || (new_t == old_t)) begin
            out       <= '0;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            out.rate_value <= quot;
            out.rate_valid <= 1'b1;
            out_valid      <= 1'b1;
            state          <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // sraddr leads idx by one entry while a read is pending, so the read for
  // the next step is issued while the current one is examined.
  // Product dc * SCALE_K in two 32x26 partial products.
  logic [57:0] pa, pb;
  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      pa <= {26'd0, dc[31:0]} * {32'd0, SCALE_K};
      pb <= {26'd0, dc[63:32]} * {32'd0, SCALE_K};
    end
  end
  assign dc = new_c - old_c;
  assign dt = new_t - old_t;
  always_comb begin
    logic [127:0] p;
    p    = {70'd0, pa} + ({70'd0, pb} << 32);
    m_lo = p[63:0];
    m_hi = p[127:64];
  end

endmodule

// ===== rtl/wrm_ram.sv =====
// ----------------------------------------------------------------------------
// wrm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module wrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wrm_div.sv =====
// ----------------------------------------------------------------------------
// wrm_div
// Radix-2 restoring divider: 128-bit dividend by 64-bit divisor, saturating.
// ----------------------------------------------------------------------------
module wrm_div
  import wrm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  hi,
  input  logic [63:0]  lo,
  input  logic [63:0]  divisor,
  output logic         done,
  output logic [63:0]  quotient
);

  logic [63:0] rem;
  logic [63:0] num;
  logic [63:0] dvs;
  logic [6:0]  bits;
  logic        busy;
  logic [64:0] shifted;
  logic        take;

  assign shifted = {rem, num[63]};
  assign take    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvs  <= divisor;
        rem  <= hi;
        num  <= lo;
        bits <= 7'd64;
        if (hi >= divisor) begin
          quotient <= '1;
          done     <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem      <= take ? 64'(shifted - {1'b0, dvs}) : shifted[63:0];
        num      <= {num[62:0], 1'b0};
        quotient <= {quotient[62:0], take};
        bits     <= bits - 7'd1;
        if (bits == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/wrm_checker.sv =====
// ----------------------------------------------------------------------------
// wrm_checker
// Port-level checks on the windowed rate meter, bound to the top level.
// ----------------------------------------------------------------------------
module wrm_checker
  import wrm_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input wrm_in_t  in,
  input logic     in_valid,
  input logic     in_stall,
  input wrm_out_t out,
  input logic     out_valid,
  input logic     out_stall
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out))
    else $error("stalled result changed");

  a_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out.rate_valid |-> out.rate_value == '0)
    else $error("invalid result carries a value");

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("word taken while result pending");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken back to back");

endmodule

bind windowed_rate_meter_core wrm_checker u_wrm_checker (.*);

// ===== test/tb_windowed_rate_meter_core.sv =====
// ----------------------------------------------------------------------------
// tb_windowed_rate_meter_core
// Self-checking bench for the windowed rate meter. It sends add and query
// words with random gaps and stalls, and runs a long output hold-off. A
// scoreboard keeps its own copy of every thread's sample ring and predicts
// each query result. Each accepted result is checked against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import wrm_pkg::*;

class rate_board;
  localparam int NTHR  = 8;
  localparam int DEPTH = 4096;

  logic [63:0] counts [NTHR][DEPTH];
  logic [63:0] stamps [NTHR][DEPTH];
  logic [11:0] heads [NTHR];
  wrm_out_t    pending [$];
  int          errors;

  function void clear();
    foreach (counts[t, i]) begin
      counts[t][i] = '0;
      stamps[t][i] = '0;
    end
    foreach (heads[t]) heads[t] = '0;
    pending.delete();
    errors = 0;
  endfunction

  function logic [63:0] scaled_rate(logic [63:0] dc, logic [63:0] dt);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = {64'd0, dc} * {102'd0, SCALE_K};
    quo  = prod / {64'd0, dt};
    if (quo[127:64] != '0) return '1;
    return quo[63:0];
  endfunction

  function void note(wrm_in_t w);
    wrm_out_t    res;
    logic [11:0] idx;
    logic [63:0] t, new_t, new_c, old_t, old_c;
    bit          have_new, have_old, covered;
    if (w.command == CMD_ADD) begin
      counts[w.thread][heads[w.thread]] = w.sample_count;
      stamps[w.thread][heads[w.thread]] = w.sample_time;
      heads[w.thread] = heads[w.thread] + 12'd1;
      return;
    end
    res = '0;
    have_new = 0;
    have_old = 0;
    covered = 0;
    new_t = '0; new_c = '0; old_t = '0; old_c = '0;
    for (int i = 1; i < DEPTH; i++) begin
      idx = heads[w.thread] - 12'(i);
      t = stamps[w.thread][idx];
      if (t == '0) break;
      if (!have_new) begin
        have_new = 1;
        new_t = t;
        new_c = counts[w.thread][idx];
      end
      if (w.query_time - t > {32'd0, w.window_ms}) begin
        covered = 1;
        break;
      end
      have_old = 1;
      old_t = t;
      old_c = counts[w.thread][idx];
    end
    if (covered && have_old && have_new && new_t != old_t) begin
      res.rate_value = scaled_rate(new_c - old_c, new_t - old_t);
      res.rate_valid = 1'b1;
    end
    pending.push_back(res);
  endfunction

  function void check(wrm_out_t got);
    wrm_out_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected rate word %h/%b", $time, got.rate_value, got.rate_valid);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.rate_value !== want.rate_value) begin
      $display("%0t: rate_value expected %h actual %h", $time, want.rate_value,
               got.rate_value);
      errors++;
    end
    if (got.rate_valid !== want.rate_valid) begin
      $display("%0t: rate_valid expected %b actual %b", $time, want.rate_valid,
               got.rate_valid);
      errors++;
    end
  endfunction
endclass

module tb_windowed_rate_meter_core;
  localparam int STALL_LIMIT = 200000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  wrm_in_t  in = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  wrm_out_t out;
  logic     out_valid;
  logic     out_stall = 1'b0;

  rate_board board;
  bit        calm = 1'b0;
  bit        squeeze = 1'b0;
  int        quiet_cycles = 0;
  int        words_sent = 0;

  windowed_rate_meter_core DUT (
    .clk(clk), .rst(rst), .in(in), .in_valid(in_valid), .in_stall(in_stall),
    .out(out), .out_valid(out_valid), .out_stall(out_stall)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send(wrm_in_t w);
    if (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic add(logic [2:0] th, logic [63:0] cnt, logic [63:0] ts);
    wrm_in_t w;
    w = '0;
    w.command = CMD_ADD;
    w.thread = th;
    w.sample_count = cnt;
    w.sample_time = ts;
    w.query_time = rand64();
    w.window_ms = $urandom;
    send(w);
  endtask

  task automatic query(logic [2:0] th, logic [63:0] now, logic [31:0] win);
    wrm_in_t w;
    w = '0;
    w.command = CMD_QUERY;
    w.thread = th;
    w.sample_count = rand64();
    w.sample_time = rand64();
    w.query_time = now;
    w.window_ms = win;
    send(w);
  endtask

  // receiver: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (squeeze) begin
      out_stall <= 1'b1;
      repeat (6000) @(negedge clk);
      squeeze = 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 37);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check(out);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_windowed_rate_meter_core: FAIL");
      $finish;
    end
  end

  initial begin
    logic [2:0]  th;
    logic [63:0] ts, cnt;
    int          n;
    board = new();
    board.clear();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: plain rate, empty ring, uncovered window, zero span
    add(3'd0, 64'd0, 64'd1);
    add(3'd0, 64'd1000, 64'd1001);
    query(3'd0, 64'd2000, 32'd1500);
    query(3'd1, 64'd2000, 32'd1500);
    query(3'd0, 64'd2000, 32'hFFFF_FFFF);
    query(3'd0, 64'd1001, 32'd0);
    // saturation
    add(3'd3, 64'd0, 64'd100);
    add(3'd3, 64'd0, 64'd101);
    add(3'd3, '1, 64'd102);
    query(3'd3, 64'd102, 32'd1);
    // timestamps wrapping through 2^64
    add(3'd7, 64'd5, '1 - 64'd1);
    add(3'd7, 64'd7, '1);
    add(3'd7, 64'd10, 64'd3);
    query(3'd7, 64'd4, 32'd5);
    query(3'd7, '1, 32'hFFFF_FFFF);
    query(3'd7, 64'd0, 32'd0);

    n = 0;
    while (n < 140) begin
      calm = (n >= 40 && n < 70);
      if (n >= 90 && n < 96 && !squeeze) squeeze = 1'b1;
      if ($urandom_range(0, 99) < 15) begin
        wrm_in_t w;
        w.command = $urandom;
        w.thread = $urandom;
        w.sample_count = rand64();
        w.sample_time = rand64();
        w.query_time = rand64();
        w.window_ms = $urandom;
        send(w);
        n++;
      end else begin
        th = $urandom;
        ts = ($urandom_range(0, 3) == 0) ? {32'hFFFF_FFFF, $urandom} : rand64();
        cnt = rand64();
        repeat ($urandom_range(1, 5)) begin
          add(th, cnt, ts);
          cnt = cnt + {$urandom_range(0, 1) ? $urandom : 32'd0, $urandom};
          ts = ts + $urandom_range(0, 3000);
          n++;
        end
        query(th, ts + $urandom_range(0, 2000),
              $urandom_range(0, 1) ? 32'($urandom_range(0, 6000)) : $urandom);
        n++;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0) $display("tb_windowed_rate_meter_core: PASS");
    else $display("tb_windowed_rate_meter_core: FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/wrm_pkg.sv
rtl/wrm_ram.sv
rtl/wrm_div.sv
rtl/windowed_rate_meter_core.sv
rtl/wrm_checker.sv
test/tb_windowed_rate_meter_core.sv
